FILE: rtl/aabb_frustum_cull_core_assert.svh
// Assertion macros used by the box culling RTL
`ifndef AABB_FRUSTUM_CULL_CORE_ASSERT_SVH
`define AABB_FRUSTUM_CULL_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define AFC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aabb_frustum_cull_core: check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define AFC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aabb_frustum_cull_core: check failed");

`endif

FILE: rtl/afc_pkg.sv
// Types and constants for the box frustum culling core
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

    localparam int MAT_DIM     = 4;
    localparam int NUM_CFG     = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int ENTRY_W     = 32;
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;
    localparam int Q_FRAC      = 16;
    localparam int MASK_W      = 6;

    // clip-space rows
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    // outcode bit positions
    localparam int OC_X_NEG = 0;
    localparam int OC_X_POS = 1;
    localparam int OC_Y_NEG = 2;
    localparam int OC_Y_POS = 3;
    localparam int OC_Z_NEAR = 4;
    localparam int OC_Z_FAR = 5;

    typedef logic [ENTRY_W-1:0] q16_t;
    typedef q16_t [MAT_DIM-1:0][MAT_DIM-1:0] mat_t;   // [row][col]
    typedef logic [MASK_W-1:0] mask_t;

    typedef enum logic [2:0] {
        CFG_ROW0_COLS01 = 3'd0,
        CFG_ROW0_COLS23 = 3'd1,
        CFG_ROW1_COLS01 = 3'd2,
        CFG_ROW1_COLS23 = 3'd3,
        CFG_ROW2_COLS01 = 3'd4,
        CFG_ROW2_COLS23 = 3'd5,
        CFG_ROW3_COLS01 = 3'd6,
        CFG_ROW3_COLS23 = 3'd7
    } cfg_idx_t;

    // identity matrix at reset
    localparam logic [CFG_DATA_W-1:0] CFG_RESET_VAL [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

`default_nettype wire

FILE: rtl/afc_box_if.sv
// Box input channel: valid/ready with min and max corners
`timescale 1ns / 1ps
`default_nettype none

interface afc_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );

    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/afc_cull_if.sv
// Cull result channel: valid/ready with visibility and outcode mask
`timescale 1ns / 1ps
`default_nettype none

interface afc_cull_if;
    logic       valid;
    logic       ready;
    logic       visible;
    logic [5:0] outside_mask;

    modport source (
        output valid, visible, outside_mask,
        input  ready
    );

    modport sink (
        input  valid, visible, outside_mask,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/aabb_frustum_cull_core.sv
// Box frustum culling core: clip-space outcodes of eight corners, ANDed
// Five register stages (coordinates, products, sums, corners, outcodes); one box per cycle
// unless the result stalls, set by 24 parallel 32xCOORD_BITS multipliers in stage two.
// Each stage holds its item while the next is blocked; bubbles are squeezed out on a stall.
// Reset clears all stage valids and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none

`include "aabb_frustum_cull_core_assert.svh"

module aabb_frustum_cull_core #(
    parameter int COORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    afc_box_if.sink                         box,
    afc_cull_if.source                      result,
    input  logic                            cfg_we,
    input  afc_pkg::cfg_idx_t               cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import afc_pkg::*;

    localparam int PROD_W   = ENTRY_W + COORD_BITS;
    localparam int SUM_W    = PROD_W + 1;
    localparam int CORNER_W = PROD_W + 2;
    localparam int TEST_W   = PROD_W + 3;
    localparam int OFS_W    = ENTRY_W + Q_FRAC;

    mat_t mat;

    afc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .mat   (mat)
    );

    // ---------------- stage control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || result.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign box.ready = rdy1;

    assign v1_next = rdy1 ? box.valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;
    assign v5_next = rdy5 ? v4_reg : v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    // ---------------- stage 1: coordinates [axis][0 = min, 1 = max] ----------------
    logic signed [COORD_BITS-1:0] crd_reg  [NUM_AXES][2];
    logic signed [COORD_BITS-1:0] crd_next [NUM_AXES][2];

    always_comb
    begin
        crd_next[0][0] = box.box_min_x[COORD_BITS-1:0];
        crd_next[1][0] = box.box_min_y[COORD_BITS-1:0];
        crd_next[2][0] = box.box_min_z[COORD_BITS-1:0];
        crd_next[0][1] = box.box_max_x[COORD_BITS-1:0];
        crd_next[1][1] = box.box_max_y[COORD_BITS-1:0];
        crd_next[2][1] = box.box_max_z[COORD_BITS-1:0];
    end

    // ---------------- stage 2: products [row][axis][min/max] ----------------
    logic signed [PROD_W-1:0] prod_reg  [MAT_DIM][NUM_AXES][2];
    logic signed [PROD_W-1:0] prod_next [MAT_DIM][NUM_AXES][2];

    always_comb
    begin
        for (int r = 0; r < MAT_DIM; r++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                for (int h = 0; h < 2; h++)
                begin
                    prod_next[r][a][h] = PROD_W'($signed(mat[r][a])) *
                                         PROD_W'(crd_reg[a][h]);
                end
            end
        end
    end

    // ---------------- stage 3: x+y pairs and z plus translation ----------------
    logic signed [SUM_W-1:0] sxy_reg  [MAT_DIM][4];
    logic signed [SUM_W-1:0] sxy_next [MAT_DIM][4];
    logic signed [SUM_W-1:0] sz_reg   [MAT_DIM][2];
    logic signed [SUM_W-1:0] sz_next  [MAT_DIM][2];
    logic signed [OFS_W-1:0] ofs      [MAT_DIM];

    always_comb
    begin
        for (int r = 0; r < MAT_DIM; r++)
        begin
            // column 3 times w = 1.0 in Q16.16
            ofs[r] = $signed({mat[r][3], {Q_FRAC{1'b0}}});
            for (int hy = 0; hy < 2; hy++)
            begin
                for (int hx = 0; hx < 2; hx++)
                begin
                    sxy_next[r][2*hy+hx] = SUM_W'(prod_reg[r][0][hx]) +
                                           SUM_W'(prod_reg[r][1][hy]);
                end
            end
            for (int hz = 0; hz < 2; hz++)
            begin
                sz_next[r][hz] = SUM_W'(prod_reg[r][2][hz]) + SUM_W'(ofs[r]);
            end
        end
    end

    // ---------------- stage 4: clip coordinates per corner ----------------
    logic signed [CORNER_W-1:0] crn_reg  [MAT_DIM][NUM_CORNERS];
    logic signed [CORNER_W-1:0] crn_next [MAT_DIM][NUM_CORNERS];

    always_comb
    begin
        for (int r = 0; r < MAT_DIM; r++)
        begin
            for (int hz = 0; hz < 2; hz++)
            begin
                for (int q = 0; q < 4; q++)
                begin
                    crn_next[r][4*hz+q] = CORNER_W'(sxy_reg[r][q]) +
                                          CORNER_W'(sz_reg[r][hz]);
                end
            end
        end
    end

    // ---------------- stage 5: outcodes, AND over corners ----------------
    mask_t mask_reg;
    mask_t mask_next;
    logic  vis_reg;
    logic  vis_next;

    logic signed [TEST_W-1:0] cw_ext;
    logic signed [TEST_W-1:0] x_add, x_sub, y_add, y_sub, z_ext, z_sub;
    mask_t                    oc;

    always_comb
    begin
        mask_next = '1;
        cw_ext = '0;
        x_add  = '0;
        x_sub  = '0;
        y_add  = '0;
        y_sub  = '0;
        z_ext  = '0;
        z_sub  = '0;
        oc     = '0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            cw_ext = TEST_W'(crn_reg[ROW_W][k]);
            x_add  = TEST_W'(crn_reg[ROW_X][k]) + cw_ext;
            x_sub  = TEST_W'(crn_reg[ROW_X][k]) - cw_ext;
            y_add  = TEST_W'(crn_reg[ROW_Y][k]) + cw_ext;
            y_sub  = TEST_W'(crn_reg[ROW_Y][k]) - cw_ext;
            z_ext  = TEST_W'(crn_reg[ROW_Z][k]);
            z_sub  = z_ext - cw_ext;
            // strict compares: a corner on a plane is inside it
            oc[OC_X_NEG]  = x_add[TEST_W-1];
            oc[OC_X_POS]  = !x_sub[TEST_W-1] && (x_sub != '0);
            oc[OC_Y_NEG]  = y_add[TEST_W-1];
            oc[OC_Y_POS]  = !y_sub[TEST_W-1] && (y_sub != '0);
            oc[OC_Z_NEAR] = z_ext[TEST_W-1];
            oc[OC_Z_FAR]  = !z_sub[TEST_W-1] && (z_sub != '0);
            mask_next     = mask_next & oc;
        end
        vis_next = (mask_next == '0);
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (rdy1 && box.valid)
        begin
            crd_reg <= crd_next;
        end
        if (rdy2 && v1_reg)
        begin
            prod_reg <= prod_next;
        end
        if (rdy3 && v2_reg)
        begin
            sxy_reg <= sxy_next;
            sz_reg  <= sz_next;
        end
        if (rdy4 && v3_reg)
        begin
            crn_reg <= crn_next;
        end
        if (rdy5 && v4_reg)
        begin
            mask_reg <= mask_next;
            vis_reg  <= vis_next;
        end
    end

    assign result.valid        = v5_reg;
    assign result.visible      = vis_reg;
    assign result.outside_mask = mask_reg;

    // ---------------- checks ----------------
    logic row0_we;

    assign row0_we = cfg_we && (cfg_index == CFG_ROW0_COLS01);

    `AFC_ASSERT_NEXT(a_accept_fills_s1, box.valid && box.ready, v1_reg)
    `AFC_ASSERT_NEXT(a_s4_holds_on_stall, v4_reg && !rdy5, v4_reg)
    `AFC_ASSERT_NOW(a_result_from_pipe, $rose(result.valid), $past(v4_reg))
    `AFC_ASSERT_NEXT(a_cfg_row0_write, row0_we, mat[0][0] == $past(cfg_wdata[ENTRY_W-1:0]))

endmodule

`default_nettype wire

FILE: rtl/afc_cfg_regs.sv
// Matrix register file: eight 64-bit words unpacked into a 4x4 Q16.16 matrix
`timescale 1ns / 1ps
`default_nettype none

module afc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            we,
    input  afc_pkg::cfg_idx_t               index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]  wdata,
    output afc_pkg::mat_t                   mat
);
    import afc_pkg::*;

    logic [CFG_DATA_W-1:0] word_reg  [NUM_CFG];
    logic [CFG_DATA_W-1:0] word_next [NUM_CFG];

    always_comb
    begin
        for (int i = 0; i < NUM_CFG; i++)
        begin
            word_next[i] = word_reg[i];
            if (we && (index == cfg_idx_t'(i)))
            begin
                word_next[i] = wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                word_reg[i] <= CFG_RESET_VAL[i];
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                word_reg[i] <= word_next[i];
            end
        end
    end

    // row r, cols {2j, 2j+1} live in word 2r+j, even column in the low half
    always_comb
    begin
        for (int r = 0; r < MAT_DIM; r++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                mat[r][2*j]   = word_reg[2*r+j][ENTRY_W-1:0];
                mat[r][2*j+1] = word_reg[2*r+j][CFG_DATA_W-1:ENTRY_W];
            end
        end
    end

endmodule

`default_nettype wire
